// ===== rtl/core/nfud_pkg.sv =====
// Shared types and constants for the nearest free unit dispatch block.
`timescale 1ns / 1ps
`default_nettype none

package nfud_pkg;

    localparam int SLOT_W  = 6;
    localparam int TAG_W   = 16;
    localparam int COORD_W = 16;
    localparam int DIST_W  = 17;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic [TAG_W-1:0]          tag_t;
    typedef logic [SLOT_W-1:0]         slot_t;

    // Request kinds carried in the input tuser field.
    localparam logic [1:0] REQ_ADD      = 2'd0;
    localparam logic [1:0] REQ_RIDE     = 2'd1;
    localparam logic [1:0] REQ_COMPLETE = 2'd2;

    // Result status codes.
    localparam logic STATUS_ASSIGNED = 1'b0;
    localparam logic STATUS_NONE     = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/nfud_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module nfud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/nfud_dist.sv =====
// Shared Manhattan distance unit: one slot per cycle, result registered.
`timescale 1ns / 1ps
`default_nettype none

module nfud_dist
    import nfud_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    input  wire coord_t unit_x,
    input  wire coord_t unit_y,
    input  wire coord_t rider_x,
    input  wire coord_t rider_y,
    output logic        hit,
    output dist_t       dist_sum
);

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W-1:0]      adx;
    logic [COORD_W-1:0]      ady;
    dist_t                   dist_next;

    always_comb begin
        dx  = {unit_x[COORD_W-1], unit_x} - {rider_x[COORD_W-1], rider_x};
        dy  = {unit_y[COORD_W-1], unit_y} - {rider_y[COORD_W-1], rider_y};
        // A difference of two 16-bit values has a magnitude below 2^16.
        adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        dist_next = DIST_W'(adx) + DIST_W'(ady);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit <= 1'b0;
        end else begin
            hit <= in_valid;
        end
        dist_sum <= dist_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/nearest_free_unit_dispatch_unit.sv =====
// Top level of the nearest free unit dispatch block.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The block keeps UNIT_SLOTS server slots, each with a position and an
// available flag. Requests arrive on the s_axis channel, the kind in tuser.
// An add request stores a slot's position and marks it available; a complete
// request marks a slot available again. Neither gives an item.
// A ride request scans every slot through one shared distance unit, one slot
// per cycle, through a read, distance and compare pipeline. The nearest
// available slot (lowest slot on a tie) is marked busy and one item appears
// on m_axis with the slot, distance and echoed rider tag, or with the "no
// unit" status. s_axis_tready stays low from acceptance of a ride request
// until its result is loaded into the output register, since the slot scan
// uses the RAM read port. After reset the block clears the position and flag
// memories, one slot per cycle, with s_axis_tready low. A result waits in an
// output register; adds and completes are still taken while it waits, and a
// finished ride holds in its last step until the register is free.
module nearest_free_unit_dispatch_unit
    import nfud_pkg::*;
#(
    parameter int UNIT_SLOTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // unit_slot[5:0], rider_tag[21:6], pos_x[37:22], pos_y[53:38], zero fill
    input  wire logic [55:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // chosen_slot[5:0], distance[22:6], tag_out[38:23], zero fill
    output logic [39:0]      m_axis_tdata,
    // status[0]
    output logic [0:0]       m_axis_tuser
);

    localparam int ADDR_W     = $clog2(UNIT_SLOTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SLOT_EXT_W = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                p1_valid_reg, p1_valid_next;
    logic [ADDR_W-1:0]   p1_idx_reg, p1_idx_next;
    logic [ADDR_W-1:0]   p2_idx_reg, p2_idx_next;
    logic                found_reg, found_next;
    logic [ADDR_W-1:0]   best_reg, best_next;
    dist_t               best_d_reg, best_d_next;
    coord_t              rider_x_reg, rider_x_next;
    coord_t              rider_y_reg, rider_y_next;
    tag_t                tag_reg, tag_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_status_reg, m_status_next;
    slot_t               m_slot_reg, m_slot_next;
    dist_t               m_dist_reg, m_dist_next;
    tag_t                m_tag_reg, m_tag_next;

    // Input field unpacking.
    logic [1:0]          in_req;
    slot_t               in_slot;
    tag_t                in_tag;
    coord_t              in_x;
    coord_t              in_y;
    logic [SLOT_EXT_W-1:0] slot_ext;
    logic                slot_ok;
    logic [ADDR_W-1:0]   slot_addr;
    logic                accept;

    // Memory ports.
    logic                pos_we;
    logic [ADDR_W-1:0]   pos_waddr;
    logic [2*COORD_W-1:0] pos_wdata;
    logic [2*COORD_W-1:0] pos_rdata;
    logic                free_we;
    logic [ADDR_W-1:0]   free_waddr;
    logic                free_wdata;
    logic                free_rdata;
    logic [ADDR_W-1:0]   rd_addr;

    // Distance unit.
    logic                dist_hit;
    dist_t               dist_val;
    logic                scan_done;

    assign in_req    = s_axis_tuser;
    assign in_slot   = s_axis_tdata[5:0];
    assign in_tag    = s_axis_tdata[21:6];
    assign in_x      = $signed(s_axis_tdata[37:22]);
    assign in_y      = $signed(s_axis_tdata[53:38]);
    assign slot_ext  = SLOT_EXT_W'(in_slot);
    // Requests naming a slot past the table are ignored.
    assign slot_ok   = (32'(in_slot) < 32'(UNIT_SLOTS));
    assign slot_addr = ADDR_W'(slot_ext);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rd_addr       = cnt_reg[ADDR_W-1:0];

    // The scan is over once every slot has been issued and the read and
    // distance stages hold nothing more to compare.
    assign scan_done = (cnt_reg == CNT_W'(UNIT_SLOTS)) && !p1_valid_reg && !dist_hit;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {1'b0, m_tag_reg, m_dist_reg, m_slot_reg};

    nfud_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (UNIT_SLOTS)
    ) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (rd_addr),
        .rdata (pos_rdata)
    );

    nfud_ram #(
        .WIDTH (1),
        .DEPTH (UNIT_SLOTS)
    ) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (rd_addr),
        .rdata (free_rdata)
    );

    nfud_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (p1_valid_reg && free_rdata),
        .unit_x   ($signed(pos_rdata[COORD_W-1:0])),
        .unit_y   ($signed(pos_rdata[2*COORD_W-1:COORD_W])),
        .rider_x  (rider_x_reg),
        .rider_y  (rider_y_reg),
        .hit      (dist_hit),
        .dist_sum (dist_val)
    );

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cnt_next      = cnt_reg;
        p1_valid_next = 1'b0;
        p1_idx_next   = rd_addr;
        p2_idx_next   = p1_idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_d_next   = best_d_reg;
        rider_x_next  = rider_x_reg;
        rider_y_next  = rider_y_reg;
        tag_next      = tag_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_dist_next   = m_dist_reg;
        m_tag_next    = m_tag_reg;

        pos_we     = 1'b0;
        pos_waddr  = slot_addr;
        pos_wdata  = {in_y, in_x};
        free_we    = 1'b0;
        free_waddr = slot_addr;
        free_wdata = 1'b1;

        unique case (state_reg)
            ST_CLEAR: begin
                // Zero positions and flags after reset, one slot per cycle.
                pos_we     = 1'b1;
                pos_waddr  = clr_cnt_reg;
                pos_wdata  = '0;
                free_we    = 1'b1;
                free_waddr = clr_cnt_reg;
                free_wdata = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(UNIT_SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_req == REQ_ADD) begin
                        pos_we  = slot_ok;
                        free_we = slot_ok;
                    end else if (in_req == REQ_COMPLETE) begin
                        free_we = slot_ok;
                    end else if (in_req == REQ_RIDE) begin
                        rider_x_next = in_x;
                        rider_y_next = in_y;
                        tag_next     = in_tag;
                        found_next   = 1'b0;
                        cnt_next     = '0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cnt_reg != CNT_W'(UNIT_SLOTS)) begin
                    p1_valid_next = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
                // Strict compare keeps the lowest slot on a tie.
                if (dist_hit && (!found_reg || (dist_val < best_d_reg))) begin
                    found_next  = 1'b1;
                    best_next   = p2_idx_reg;
                    best_d_next = dist_val;
                end
                if (scan_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = found_reg ? STATUS_ASSIGNED : STATUS_NONE;
                    m_slot_next   = found_reg ? SLOT_W'(best_reg) : '0;
                    m_dist_next   = found_reg ? best_d_reg : '0;
                    m_tag_next    = tag_reg;
                    // The chosen unit becomes busy.
                    free_we       = found_reg;
                    free_waddr    = best_reg;
                    free_wdata    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            cnt_reg      <= '0;
            p1_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            cnt_reg      <= cnt_next;
            p1_valid_reg <= p1_valid_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
        p1_idx_reg   <= p1_idx_next;
        p2_idx_reg   <= p2_idx_next;
        best_reg     <= best_next;
        best_d_reg   <= best_d_next;
        rider_x_reg  <= rider_x_next;
        rider_y_reg  <= rider_y_next;
        tag_reg      <= tag_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_dist_reg   <= m_dist_next;
        m_tag_reg    <= m_tag_next;
    end

endmodule

`default_nettype wire
